[rtl/tle_pkg.sv]
// Shared types, character constants and the microprogram of the terminal line editor.
// Used by tle_seq, tle_dp and the top module; depends on nothing else.
package tle_pkg;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_DEL      = 8'h7F;

  typedef enum logic [1:0] {
    K_ECHO  = 2'd0,
    K_LINE  = 2'd1,
    K_EVENT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_ENTER = 3'd1,
    EV_TAB   = 3'd2,
    EV_UP    = 3'd3,
    EV_DOWN  = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CONST,
    EM_CHAR,
    EM_LINE,
    EM_EVENT
  } emit_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_END_NEXT,
    J_END_STAY
  } jmp_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_LATCH,
    A_DECODE,
    A_IDX_INC,
    A_EV_END
  } act_t;

  typedef enum logic [2:0] {
    CL_IGNORE,
    CL_ENTER,
    CL_BS,
    CL_ECHO,
    CL_STREAM
  } cls_t;

  typedef logic [3:0] step_t;

  localparam step_t P_IDLE   = 4'd0;
  localparam step_t P_DECODE = 4'd1;
  localparam step_t P_CR     = 4'd2;
  localparam step_t P_LF     = 4'd3;
  localparam step_t P_BS1    = 4'd4;
  localparam step_t P_BS2    = 4'd5;
  localparam step_t P_BS3    = 4'd6;
  localparam step_t P_ECHO   = 4'd7;
  localparam step_t P_RD     = 4'd8;
  localparam step_t P_OUT    = 4'd9;
  localparam step_t P_EVENT  = 4'd10;

  typedef struct packed {
    logic       wait_in;
    emit_t      emit;
    logic [7:0] cbyte;
    logic       last;
    jmp_t       jmp;
    step_t      target;
    act_t       act;
  } ctrl_t;

  typedef struct packed {
    ctrl_t w;
    logic  go;
  } seq_ctl_t;

  typedef struct packed {
    cls_t cls;
    logic idx_end;
  } dp_stat_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    ev_t        ev;
    logic [5:0] count;
    logic       last;
  } beat_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w         = '0;
    w.emit    = EM_NONE;
    w.jmp     = J_GOTO;
    w.target  = P_IDLE;
    w.act     = A_NONE;
    unique case (s)
      P_IDLE: begin
        w.wait_in = 1'b1;
        w.act     = A_LATCH;
        w.jmp     = J_NEXT;
      end
      P_DECODE: begin
        w.jmp = J_DISPATCH;
        w.act = A_DECODE;
      end
      P_CR: begin
        w.emit  = EM_CONST;
        w.cbyte = CH_CR;
        w.jmp   = J_NEXT;
      end
      P_LF: begin
        w.emit   = EM_CONST;
        w.cbyte  = CH_LF;
        w.target = P_RD;
      end
      P_BS1: begin
        w.emit  = EM_CONST;
        w.cbyte = CH_BS;
        w.jmp   = J_NEXT;
      end
      P_BS2: begin
        w.emit  = EM_CONST;
        w.cbyte = CH_SPACE;
        w.jmp   = J_NEXT;
      end
      P_BS3: begin
        w.emit  = EM_CONST;
        w.cbyte = CH_BS;
        w.last  = 1'b1;
      end
      P_ECHO: begin
        w.emit = EM_CHAR;
        w.last = 1'b1;
      end
      P_RD: begin
        w.jmp    = J_END_NEXT;
        w.target = P_EVENT;
      end
      P_OUT: begin
        w.emit   = EM_LINE;
        w.act    = A_IDX_INC;
        w.jmp    = J_END_STAY;
        w.target = P_EVENT;
      end
      P_EVENT: begin
        w.emit = EM_EVENT;
        w.last = 1'b1;
        w.act  = A_EV_END;
      end
      default: begin
        w.target = P_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic step_t class_target(input cls_t c);
    step_t s;
    unique case (c)
      CL_ENTER:  s = P_CR;
      CL_BS:     s = P_BS1;
      CL_ECHO:   s = P_ECHO;
      CL_STREAM: s = P_RD;
      default:   s = P_IDLE;
    endcase
    return s;
  endfunction

endpackage

[rtl/tle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tle_seq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on tle_pkg for the control word and the microprogram.
module tle_seq
  import tle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_free,
  input  dp_stat_t stat,
  output logic     in_stall,
  output seq_ctl_t ctl
);

  step_t pc;
  step_t pc_next;
  ctrl_t w;
  logic  go;

  always_comb begin
    w = ucode(pc);
    if (w.emit != EM_NONE) begin
      go = out_free;
    end else if (w.wait_in) begin
      go = in_valid;
    end else begin
      go = 1'b1;
    end
  end

  always_comb begin
    unique case (w.jmp)
      J_NEXT:     pc_next = pc + 1'b1;
      J_GOTO:     pc_next = w.target;
      J_DISPATCH: pc_next = class_target(stat.cls);
      J_END_NEXT: pc_next = stat.idx_end ? w.target : pc + 1'b1;
      J_END_STAY: pc_next = stat.idx_end ? w.target : pc;
      default:    pc_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_IDLE;
    end else if (go) begin
      pc <= pc_next;
    end
  end

  assign in_stall = !w.wait_in;
  assign ctl.w    = w;
  assign ctl.go   = go;

endmodule

[rtl/tle_dp.sv]
// Datapath: byte decode, line length and colon tracking, escape state, line store.
// Depends on tle_pkg and tle_ram; driven by the control word of tle_seq.
module tle_dp
  import tle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  seq_ctl_t   ctl,
  input  logic [7:0] rx_char,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output dp_stat_t   stat,
  output beat_t      beat
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = $clog2(LINE_DEPTH + 1);

  logic          logged_in;
  logic [7:0]    ch;
  logic          in_escape;
  logic          escape_count;
  logic [7:0]    escape_first;
  logic [LW-1:0] line_length;
  logic          colon_seen;
  logic [AW-1:0] colon_index;
  ev_t           ev;
  logic [7:0]    echo_byte;
  logic [LW-1:0] idx;

  logic          in_escape_next;
  logic          escape_count_next;
  logic [7:0]    escape_first_next;
  logic [LW-1:0] line_length_next;
  logic          colon_seen_next;
  logic [AW-1:0] colon_index_next;
  ev_t           ev_next;
  logic [7:0]    echo_byte_next;
  logic [LW-1:0] idx_next;
  logic [LW-1:0] idx_cmp;
  logic [LW-1:0] len_dec;
  cls_t          cls;
  logic          wr;
  logic          decode;
  logic [7:0]    rdata;

  assign decode  = ctl.go && (ctl.w.act == A_DECODE);
  assign len_dec = line_length - 1'b1;

  always_comb begin
    cls               = CL_IGNORE;
    wr                = 1'b0;
    in_escape_next    = in_escape;
    escape_count_next = escape_count;
    escape_first_next = escape_first;
    line_length_next  = line_length;
    colon_seen_next   = colon_seen;
    colon_index_next  = colon_index;
    ev_next           = ev;
    echo_byte_next    = echo_byte;
    priority if (in_escape) begin
      if (!escape_count) begin
        escape_first_next = ch;
        escape_count_next = 1'b1;
      end else begin
        in_escape_next    = 1'b0;
        escape_count_next = 1'b0;
        if (logged_in && escape_first == CH_LBRACKET) begin
          if (ch == CH_A) begin
            cls     = CL_STREAM;
            ev_next = EV_UP;
          end else if (ch == CH_B) begin
            cls     = CL_STREAM;
            ev_next = EV_DOWN;
          end
        end
      end
    end else if (ch == CH_CR || ch == CH_LF) begin
      if (line_length != '0) begin
        cls     = CL_ENTER;
        ev_next = EV_ENTER;
      end
    end else if (ch == CH_ESC) begin
      in_escape_next    = 1'b1;
      escape_count_next = 1'b0;
    end else if (ch < CH_SPACE || ch == CH_DEL) begin
      if (ch == CH_BS || ch == CH_DEL) begin
        if (line_length != '0) begin
          cls              = CL_BS;
          line_length_next = len_dec;
          if (colon_seen && colon_index == len_dec[AW-1:0]) begin
            colon_seen_next = 1'b0;
          end
        end
      end else if (ch == CH_TAB && logged_in) begin
        cls     = CL_STREAM;
        ev_next = EV_TAB;
      end
    end else begin
      if (line_length < LW'(LINE_DEPTH)) begin
        cls              = CL_ECHO;
        wr               = 1'b1;
        line_length_next = line_length + 1'b1;
        if (ch == CH_COLON && !colon_seen) begin
          colon_seen_next  = 1'b1;
          colon_index_next = line_length[AW-1:0];
        end
        echo_byte_next = (!logged_in && colon_seen) ? CH_STAR : ch;
      end
    end
  end

  always_comb begin
    idx_cmp = (ctl.w.act == A_IDX_INC) ? idx + 1'b1 : idx;
    if (decode) begin
      idx_next = '0;
    end else if (ctl.go && ctl.w.act == A_IDX_INC) begin
      idx_next = idx_cmp;
    end else begin
      idx_next = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      logged_in    <= 1'b0;
      in_escape    <= 1'b0;
      escape_count <= 1'b0;
      escape_first <= '0;
      line_length  <= '0;
      colon_seen   <= 1'b0;
      colon_index  <= '0;
      ev           <= EV_NONE;
      idx          <= '0;
    end else begin
      if (cfg_we) begin
        logged_in <= cfg_wdata;
      end
      idx <= idx_next;
      if (decode) begin
        in_escape    <= in_escape_next;
        escape_count <= escape_count_next;
        escape_first <= escape_first_next;
        line_length  <= line_length_next;
        colon_seen   <= colon_seen_next;
        colon_index  <= colon_index_next;
        ev           <= ev_next;
      end else if (ctl.go && ctl.w.act == A_EV_END && ev == EV_ENTER) begin
        line_length <= '0;
        colon_seen  <= 1'b0;
        colon_index <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && ctl.w.act == A_LATCH) begin
      ch <= rx_char;
    end
    if (decode) begin
      echo_byte <= echo_byte_next;
    end
  end

  tle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (decode && wr),
    .waddr(line_length[AW-1:0]),
    .wdata(ch),
    .raddr(idx_next[AW-1:0]),
    .rdata(rdata)
  );

  assign stat.cls     = cls;
  assign stat.idx_end = (idx_cmp == line_length);

  always_comb begin
    beat.kind  = K_ECHO;
    beat.data  = '0;
    beat.ev    = EV_NONE;
    beat.count = '0;
    beat.last  = ctl.w.last;
    unique case (ctl.w.emit)
      EM_CONST: beat.data = ctl.w.cbyte;
      EM_CHAR:  beat.data = echo_byte;
      EM_LINE: begin
        beat.kind = K_LINE;
        beat.data = rdata;
      end
      EM_EVENT: begin
        beat.kind  = K_EVENT;
        beat.ev    = ev;
        beat.count = 6'(line_length);
      end
      default: beat.data = '0;
    endcase
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LW'(LINE_DEPTH))
    else $error("line length beyond store depth");

  a_colon_inside: assert property (@(posedge clk) disable iff (rst)
    colon_seen |-> (LW'(colon_index) < line_length))
    else $error("tracked colon lies outside the line");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (ctl.w.emit == EM_LINE) |-> (idx < line_length))
    else $error("stream index ran past the line");

  a_escape_count: assert property (@(posedge clk) disable iff (rst)
    !in_escape |-> !escape_count)
    else $error("escape count set outside a sequence");

endmodule

[rtl/terminal_line_editor_top.sv]
// Terminal line editor: sequencer, datapath and the output beat register.
// Depends on tle_pkg, tle_seq, tle_dp and tle_ram.
// Each input byte is latched in the idle step and classified in the decode step; the
// sequencer then emits its result beats (echo, backspace, line stream, event) into the
// output beat register and takes no new byte until it is back in the idle step; stalls hold it.
// Reset (synchronous) empties the line, ends any escape sequence and selects logged-out mode.
module terminal_line_editor_top
  import tle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_char,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] event_code,
  output logic [5:0] line_count,
  output logic       last
);

  seq_ctl_t ctl;
  dp_stat_t stat;
  beat_t    beat;
  logic     out_free;
  logic     load;

  assign out_free = !out_valid || !out_stall;
  assign load     = ctl.go && (ctl.w.emit != EM_NONE);

  tle_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .out_free(out_free),
    .stat    (stat),
    .in_stall(in_stall),
    .ctl     (ctl)
  );

  tle_dp #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rx_char  (rx_char),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .stat     (stat),
    .beat     (beat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= beat.kind;
      out_byte   <= beat.data;
      event_code <= beat.ev;
      line_count <= beat.count;
      last       <= beat.last;
    end
  end

endmodule
